>>> src/ctss_pkg.sv
`timescale 1ns / 1ps
package ctss_pkg;

  localparam int PALETTE_MAX   = 4;
  localparam int MIN_PERIOD_MS = 300;
  localparam int MAX_PERIOD_MS = 4000;
  localparam int SPEED_MAX     = 100;
  localparam int QUEUE_DEPTH   = 4;

  typedef enum logic [2:0] {
    DIR_FWD      = 3'd0,
    DIR_REV      = 3'd1,
    DIR_PINGPONG = 3'd2,
    DIR_DUAL_IN  = 3'd3,
    DIR_DUAL_OUT = 3'd4
  } dir_t;

  typedef enum logic [2:0] {
    REG_SPEED    = 3'd0,
    REG_BAND     = 3'd1,
    REG_AXIS     = 3'd2,
    REG_DIR      = 3'd3,
    REG_COUNT    = 3'd4,
    REG_PAL_LO   = 3'd5,
    REG_PAL_HI   = 3'd6
  } reg_idx_t;

  typedef logic [15:0] period_tab_t [0:SPEED_MAX];

  function automatic period_tab_t build_period_tab();
    period_tab_t tab;
    longint span;
    longint p;
    int sc;
    span = (MAX_PERIOD_MS > MIN_PERIOD_MS) ? longint'(MAX_PERIOD_MS - MIN_PERIOD_MS) : 64'sd0;
    for (int s = 0; s <= SPEED_MAX; s++) begin
      sc = (s < 1) ? 1 : s;
      p = longint'(MAX_PERIOD_MS) - (span * longint'(sc - 1)) / 99;
      if (p == 0) p = 1;
      tab[s] = 16'(p);
    end
    return tab;
  endfunction

  localparam period_tab_t PERIOD_TAB = build_period_tab();

  // settled configuration, recomputed every cycle from the registers
  typedef struct packed {
    logic [2:0]         dir;
    logic [15:0]        p;
    logic [16:0]        p2;
    logic [16:0]        w;
    logic [2:0]         count;
    logic [18:0]        axis;
    logic [19:0]        t;
    logic [20:0]        at;
    logic signed [21:0] base;
    logic [5:1][19:0]   kw;
    logic [3:0][23:0]   pal;
  } cfg_t;

  typedef struct packed {
    logic        dual;
    logic        flip;
    logic [15:0] m;
    logic [18:0] coord;
  } front_t;

  function automatic logic [23:0] band_color(input logic [3:0][23:0] pal,
                                             input logic [2:0] count,
                                             input logic [2:0] idx);
    logic [23:0] c;
    c = '0;
    if (idx != 3'd0 && idx <= count) c = pal[2'(idx - 3'd1)];
    return c;
  endfunction

  function automatic logic [23:0] mix(input logic [23:0] a, input logic [23:0] b,
                                      input logic [7:0] f);
    logic [23:0] o;
    logic [16:0] v;
    o = '0;
    for (int ch = 0; ch < 3; ch++) begin
      v = 17'(a[8*ch +: 8]) * 17'(9'd256 - {1'b0, f})
        + 17'(b[8*ch +: 8]) * 17'({1'b0, f} + 9'd1);
      o[8*ch +: 8] = v[15:8];
    end
    return o;
  endfunction

  function automatic logic [23:0] sat_add(input logic [23:0] a, input logic [23:0] b);
    logic [23:0] o;
    logic [8:0]  v;
    o = '0;
    for (int ch = 0; ch < 3; ch++) begin
      v = {1'b0, a[8*ch +: 8]} + {1'b0, b[8*ch +: 8]};
      o[8*ch +: 8] = v[8] ? 8'hFF : v[7:0];
    end
    return o;
  endfunction

endpackage

>>> src/ctss_if.sv
`timescale 1ns / 1ps
interface ctss_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_ms;
  logic [18:0] coord;
  modport source(output valid, output time_ms, output coord, input ready);
  modport sink(input valid, input time_ms, input coord, output ready);
endinterface

interface ctss_color_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface

>>> src/ctss_cfg.sv
`timescale 1ns / 1ps
module ctss_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [5:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output ctss_pkg::cfg_t   cfg
);
  import ctss_pkg::*;

  logic [7:0]  speed_pct;
  logic [16:0] band_width;
  logic [18:0] axis_length;
  logic [2:0]  direction;
  logic [2:0]  palette_count;
  logic [47:0] palette_lo;
  logic [47:0] palette_hi;

  reg_idx_t ridx;
  logic     wr;
  logic [6:0]  sidx;
  logic [2:0]  cnt;
  logic [16:0] w1;
  logic [19:0] t;
  cfg_t        cfg_next;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_pct     <= 8'd50;
      band_width    <= 17'd4096;
      axis_length   <= 19'd65536;
      direction     <= DIR_FWD;
      palette_count <= 3'd1;
      palette_lo    <= '0;
      palette_hi    <= '0;
    end else if (wr) begin
      case (ridx)
        REG_SPEED:  speed_pct     <= pwdata[7:0];
        REG_BAND:   band_width    <= pwdata[16:0];
        REG_AXIS:   axis_length   <= pwdata[18:0];
        REG_DIR:    direction     <= pwdata[2:0];
        REG_COUNT:  palette_count <= pwdata[2:0];
        REG_PAL_LO: palette_lo    <= pwdata[47:0];
        REG_PAL_HI: palette_hi    <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_SPEED:  prdata = {56'b0, speed_pct};
      REG_BAND:   prdata = {47'b0, band_width};
      REG_AXIS:   prdata = {45'b0, axis_length};
      REG_DIR:    prdata = {61'b0, direction};
      REG_COUNT:  prdata = {61'b0, palette_count};
      REG_PAL_LO: prdata = {16'b0, palette_lo};
      REG_PAL_HI: prdata = {16'b0, palette_hi};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (speed_pct == 8'd0) sidx = 7'd1;
    else if (speed_pct > 8'(SPEED_MAX)) sidx = 7'(SPEED_MAX);
    else sidx = speed_pct[6:0];
    cnt = (palette_count > 3'(PALETTE_MAX)) ? 3'(PALETTE_MAX) : palette_count;
    w1  = (band_width == 17'd0) ? 17'd1 : band_width;
    t   = 20'(w1 * ({1'b0, cnt} + 4'd2));
    cfg_next.dir   = direction;
    cfg_next.p     = PERIOD_TAB[sidx];
    cfg_next.p2    = {PERIOD_TAB[sidx], 1'b0};
    cfg_next.w     = w1;
    cfg_next.count = cnt;
    cfg_next.axis  = axis_length;
    cfg_next.t     = t;
    cfg_next.at    = 21'(axis_length) + 21'(t);
    cfg_next.base  = 22'({4'b0, axis_length[18:1]}) - 22'({3'b0, t[19:1]});
    for (int k = 1; k <= 5; k++) cfg_next.kw[k] = 20'(w1 * 3'(k));
    cfg_next.pal   = {palette_hi, palette_lo};
  end

  always_ff @(posedge clk) begin
    cfg <= cfg_next;
  end

endmodule

>>> src/ctss_front.sv
`timescale 1ns / 1ps
module ctss_front (
  input  logic             clk,
  input  logic             rst,
  input  ctss_pkg::cfg_t   cfg,
  ctss_pixel_if.sink       pixel,
  output logic             q_push,
  output ctss_pkg::front_t q_data,
  input  logic             q_full
);
  import ctss_pkg::*;

  localparam int NS = 32;

  logic        vld  [0:NS];
  logic [16:0] rem  [0:NS];
  logic [31:0] tm   [0:NS];
  logic [18:0] crd  [0:NS];
  logic [17:0] cat  [0:NS-1];
  logic [16:0] nrem [0:NS-1];

  logic        adv;
  logic        cv;
  front_t      cls;
  front_t      cls_next;
  logic [16:0] div;
  logic [16:0] r;
  logic [16:0] p17;
  logic [16:0] tri_val;

  assign adv         = !(cv && q_full);
  assign pixel.ready = adv;
  assign q_push      = cv && !q_full;
  assign q_data      = cls;

  // bounce and dual modes fold time over two periods
  assign div = (cfg.dir == DIR_PINGPONG || cfg.dir == DIR_DUAL_IN || cfg.dir == DIR_DUAL_OUT)
             ? cfg.p2 : {1'b0, cfg.p};

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      cat[i]  = {rem[i], tm[i][NS-1-i]};
      nrem[i] = (cat[i] >= {1'b0, div}) ? 17'(cat[i] - {1'b0, div}) : cat[i][16:0];
    end
  end

  always_comb begin
    r       = rem[NS];
    p17     = {1'b0, cfg.p};
    tri_val = (r < p17) ? r : 17'(cfg.p2 - r);
    cls_next.dual  = 1'b0;
    cls_next.flip  = 1'b0;
    cls_next.m     = r[15:0];
    cls_next.coord = crd[NS];
    case (cfg.dir)
      DIR_REV: begin
        cls_next.flip = 1'b1;
      end
      DIR_PINGPONG: begin
        if (r >= p17) begin
          cls_next.flip = 1'b1;
          cls_next.m    = 16'(r - p17);
        end
      end
      DIR_DUAL_IN: begin
        cls_next.dual = 1'b1;
        cls_next.m    = 16'(p17 - tri_val);
      end
      DIR_DUAL_OUT: begin
        cls_next.dual = 1'b1;
        cls_next.m    = tri_val[15:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NS; i++) vld[i] <= 1'b0;
      cv <= 1'b0;
    end else if (adv) begin
      vld[0] <= pixel.valid;
      for (int i = 0; i < NS; i++) vld[i+1] <= vld[i];
      cv <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tm[0]  <= pixel.time_ms;
      crd[0] <= pixel.coord;
      rem[0] <= '0;
      for (int i = 0; i < NS; i++) begin
        rem[i+1] <= nrem[i];
        tm[i+1]  <= tm[i];
        crd[i+1] <= crd[i];
      end
      cls <= cls_next;
    end
  end

endmodule

>>> src/ctss_queue.sv
`timescale 1ns / 1ps
module ctss_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ctss_pkg::front_t wdata,
  input  logic             pop,
  output ctss_pkg::front_t rdata,
  output logic             full,
  output logic             empty
);
  import ctss_pkg::*;

  localparam int PTRW = $clog2(QUEUE_DEPTH);

  front_t          mem [0:QUEUE_DEPTH-1];
  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic [PTRW:0]   fill;

  assign full  = (fill == (PTRW+1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

>>> src/ctss_back.sv
`timescale 1ns / 1ps
module ctss_back (
  input  logic             clk,
  input  logic             rst,
  input  ctss_pkg::cfg_t   cfg,
  input  ctss_pkg::front_t q_data,
  input  logic             q_empty,
  output logic             q_pop,
  ctss_color_if.source     color
);
  import ctss_pkg::*;

  localparam int QS = 21;
  localparam int FS = 8;

  // edge divider: quotient of up to 21 bits, divisor P or 2P
  logic        qv    [0:QS];
  logic [16:0] qrem  [0:QS];
  logic [36:0] qnum  [0:QS];
  logic [20:0] qq    [0:QS];
  logic        qdual [0:QS];
  logic        qflip [0:QS];
  logic [18:0] qcrd  [0:QS];
  logic [17:0] qcat  [0:QS-1];
  logic [16:0] qd    [0:QS-1];
  logic        qge   [0:QS-1];

  // band fraction divider, one lane per train
  logic        fv    [0:FS];
  logic [16:0] frem  [0:FS][0:1];
  logic [24:0] fx    [0:FS][0:1];
  logic [7:0]  fq    [0:FS][0:1];
  logic [2:0]  fidx  [0:FS][0:1];
  logic        fblk  [0:FS][0:1];
  logic [17:0] fcat  [0:FS-1][0:1];
  logic        fge   [0:FS-1][0:1];

  logic               adv;
  logic [20:0]        mult_b;
  logic [36:0]        prod;
  logic               ev;
  logic signed [23:0] ed [0:1];
  logic signed [23:0] ed_next [0:1];
  logic signed [23:0] crd24, ax24, t24, base24, q24, u24, dv, kwv, sel;
  logic [2:0]         idx_c  [0:1];
  logic               blk_c  [0:1];
  logic [24:0]        x_c    [0:1];
  logic [16:0]        remv;
  logic               mv;
  logic [23:0]        mc     [0:1];
  logic [23:0]        mc_next [0:1];
  logic               ov;
  logic [23:0]        oc;

  assign adv   = !(ov && !color.ready);
  assign q_pop = adv && !q_empty;

  assign mult_b = q_data.dual ? 21'(cfg.axis) : cfg.at;
  assign prod   = q_data.m * mult_b;

  always_comb begin
    for (int i = 0; i < QS; i++) begin
      qd[i]   = qdual[i] ? cfg.p2 : {1'b0, cfg.p};
      qcat[i] = {qrem[i], qnum[i][QS-1-i]};
      qge[i]  = (qcat[i] >= {1'b0, qd[i]});
    end
  end

  // train offsets and distance from each train's edge
  always_comb begin
    crd24  = 24'(qcrd[QS]);
    ax24   = 24'(cfg.axis);
    t24    = 24'(cfg.t);
    base24 = 24'(cfg.base);
    q24    = 24'(qq[QS]);
    u24    = qflip[QS] ? ax24 - crd24 : crd24;
    if (qdual[QS]) begin
      ed_next[0] = crd24 - base24 + q24;
      ed_next[1] = crd24 - base24 - q24;
    end else begin
      ed_next[0] = u24 - q24 + t24;
      ed_next[1] = -24'sd1;
    end
  end

  // band index by comparing against multiples of the band width
  always_comb begin
    remv = '0;
    for (int tr = 0; tr < 2; tr++) begin
      dv  = ed[tr];
      sel = '0;
      idx_c[tr] = '0;
      blk_c[tr] = dv[23] || (dv >= t24);
      for (int k = 1; k <= 5; k++) begin
        kwv = 24'(cfg.kw[k]);
        if (dv >= kwv) begin
          idx_c[tr] = 3'(k);
          sel = kwv;
        end
      end
      remv = 17'(dv - sel);
      x_c[tr] = {remv, 8'b0} - {8'b0, remv};
    end
  end

  always_comb begin
    for (int i = 0; i < FS; i++) begin
      for (int tr = 0; tr < 2; tr++) begin
        fcat[i][tr] = {frem[i][tr], fx[i][tr][FS-1-i]};
        fge[i][tr]  = (fcat[i][tr] >= {1'b0, cfg.w});
      end
    end
  end

  always_comb begin
    for (int tr = 0; tr < 2; tr++) begin
      mc_next[tr] = fblk[FS][tr] ? 24'd0
                  : mix(band_color(cfg.pal, cfg.count, fidx[FS][tr]),
                        band_color(cfg.pal, cfg.count, 3'(fidx[FS][tr] + 3'd1)),
                        fq[FS][tr]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= QS; i++) qv[i] <= 1'b0;
      for (int i = 0; i <= FS; i++) fv[i] <= 1'b0;
      ev <= 1'b0;
      mv <= 1'b0;
      ov <= 1'b0;
    end else if (adv) begin
      qv[0] <= !q_empty;
      for (int i = 0; i < QS; i++) qv[i+1] <= qv[i];
      ev    <= qv[QS];
      fv[0] <= ev;
      for (int i = 0; i < FS; i++) fv[i+1] <= fv[i];
      mv <= fv[FS];
      ov <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qrem[0]  <= {1'b0, prod[36:21]};
      qnum[0]  <= prod;
      qq[0]    <= '0;
      qdual[0] <= q_data.dual;
      qflip[0] <= q_data.flip;
      qcrd[0]  <= q_data.coord;
      for (int i = 0; i < QS; i++) begin
        qrem[i+1]  <= qge[i] ? 17'(qcat[i] - {1'b0, qd[i]}) : qcat[i][16:0];
        qnum[i+1]  <= qnum[i];
        qq[i+1]    <= {qq[i][QS-2:0], qge[i]};
        qdual[i+1] <= qdual[i];
        qflip[i+1] <= qflip[i];
        qcrd[i+1]  <= qcrd[i];
      end
      for (int tr = 0; tr < 2; tr++) begin
        ed[tr]       <= ed_next[tr];
        frem[0][tr]  <= x_c[tr][24:8];
        fx[0][tr]    <= x_c[tr];
        fq[0][tr]    <= '0;
        fidx[0][tr]  <= idx_c[tr];
        fblk[0][tr]  <= blk_c[tr];
        for (int i = 0; i < FS; i++) begin
          frem[i+1][tr] <= fge[i][tr] ? 17'(fcat[i][tr] - {1'b0, cfg.w}) : fcat[i][tr][16:0];
          fx[i+1][tr]   <= fx[i][tr];
          fq[i+1][tr]   <= {fq[i][tr][FS-2:0], fge[i][tr]};
          fidx[i+1][tr] <= fidx[i][tr];
          fblk[i+1][tr] <= fblk[i][tr];
        end
        mc[tr] <= mc_next[tr];
      end
      oc <= sat_add(mc[0], mc[1]);
    end
  end

  assign color.valid = ov;
  assign color.red   = oc[23:16];
  assign color.green = oc[15:8];
  assign color.blue  = oc[7:0];

endmodule

>>> src/color_train_sweep_sampler_top.sv
`timescale 1ns / 1ps
// Moving palette train sampler: one pixel in, one RGB color out.
// pixel channel: valid/ready transfer of time_ms and coord (Q3.16).
// color channel: valid/ready transfer of red, green, blue.
// Registers sit on an APB port, 64-bit data, register n at byte 8*n;
// write them only while no pixel is in flight.
// Throughput: one pixel per cycle, sustained, with no gaps, as long
// as the color receiver keeps ready high.
// The front takes time mod period through a 32-stage restoring divider;
// the back runs a 21-stage divider for the train edge and an 8-stage one
// for the blend fraction, then blends and saturates.
// A four-entry queue sits between front and back, so each side stalls on
// its own; when the color receiver stalls, the back holds, the queue fills
// and then the front drops pixel.ready.
// Reset empties both pipelines and the queue and loads the register
// defaults; pixel.ready is high from the first cycle after reset.
module color_train_sweep_sampler_top (
  input  logic         clk,
  input  logic         rst,
  ctss_pixel_if.sink   pixel,
  ctss_color_if.source color,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import ctss_pkg::*;

  cfg_t   cfg;
  front_t f_data;
  front_t b_data;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;

  ctss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ctss_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pixel  (pixel),
    .q_push (q_push),
    .q_data (f_data),
    .q_full (q_full)
  );

  ctss_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (f_data),
    .pop   (q_pop),
    .rdata (b_data),
    .full  (q_full),
    .empty (q_empty)
  );

  ctss_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_data  (b_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .color   (color)
  );

endmodule

>>> test/color_train_sweep_sampler_top_tb.sv
`timescale 1ns / 1ps
module color_train_sweep_sampler_top_tb;
  import ctss_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     DRAIN_CYCLES = 100;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  ctss_pixel_if pix();
  ctss_color_if col();

  color_train_sweep_sampler_top dut (
    .clk(clk), .rst(rst), .pixel(pix), .color(col),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the register file
  logic [7:0]  sh_speed;
  logic [16:0] sh_band;
  logic [18:0] sh_axis;
  logic [2:0]  sh_dir;
  logic [2:0]  sh_count;
  logic [47:0] sh_pal_lo;
  logic [47:0] sh_pal_hi;

  logic [23:0] color_q[$];
  int          err_count;
  longint      cycles;
  bit          no_idle;
  int          stall_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("color_train_sweep_sampler_top_tb: errors");
      $finish;
    end
  end

  function automatic longint period_of(logic [7:0] spd);
    longint s;
    longint p;
    s = spd;
    if (s < 1) s = 1;
    if (s > 100) s = 100;
    p = MAX_PERIOD_MS - ((MAX_PERIOD_MS - MIN_PERIOD_MS) * (s - 1)) / 99;
    return (p == 0) ? 1 : p;
  endfunction

  function automatic logic [23:0] band_pick(longint idx, longint cnt);
    logic [47:0] word;
    longint k;
    if (idx <= 0 || idx > cnt) return 24'd0;
    k = (idx - 1) & 3;
    word = (k < 2) ? sh_pal_lo : sh_pal_hi;
    return (k & 1) ? word[47:24] : word[23:0];
  endfunction

  function automatic logic [23:0] blend(logic [23:0] a, logic [23:0] b, longint f);
    logic [23:0] o;
    longint ca;
    longint cb;
    longint v;
    for (int ch = 0; ch < 3; ch++) begin
      ca = a[8*ch +: 8];
      cb = b[8*ch +: 8];
      v = (ca * 256 + cb + cb * f - ca * f) >> 8;
      o[8*ch +: 8] = v[7:0];
    end
    return o;
  endfunction

  function automatic logic [23:0] train_sample(longint u, longint lead, longint w, longint cnt);
    longint d;
    longint idx;
    longint f;
    d = u - lead;
    if (d < 0) return 24'd0;
    idx = d / w;
    if (idx >= cnt + 2) return 24'd0;
    f = ((d % w) * 255) / w;
    return blend(band_pick(idx, cnt), band_pick(idx + 1, cnt), f);
  endfunction

  function automatic logic [23:0] saturate_sum(logic [23:0] a, logic [23:0] b);
    logic [23:0] o;
    int v;
    for (int ch = 0; ch < 3; ch++) begin
      v = a[8*ch +: 8] + b[8*ch +: 8];
      o[8*ch +: 8] = (v > 255) ? 8'hFF : v[7:0];
    end
    return o;
  endfunction

  function automatic logic [23:0] pixel_color(logic [31:0] tm, logic [18:0] crd);
    longint cnt;
    longint w;
    longint p;
    longint a;
    longint t;
    longint r;
    longint tri_v;
    longint sep;
    longint off;
    longint base;
    longint leg;
    longint lead;
    bit     flip;
    cnt = (sh_count > PALETTE_MAX) ? PALETTE_MAX : sh_count;
    w = (sh_band == 0) ? 1 : sh_band;
    p = period_of(sh_speed);
    a = sh_axis;
    t = w * (cnt + 2);
    if (sh_dir == DIR_DUAL_IN || sh_dir == DIR_DUAL_OUT) begin
      r = longint'(tm) % (2 * p);
      tri_v = (r < p) ? r : 2 * p - r;
      sep = (sh_dir == DIR_DUAL_OUT) ? tri_v : p - tri_v;
      off = (sep * a) / (2 * p);
      base = (a >> 1) - (t >> 1);
      return saturate_sum(train_sample(crd, base - off, w, cnt),
                          train_sample(crd, base + off, w, cnt));
    end
    if (sh_dir == DIR_PINGPONG) begin
      r = longint'(tm) % (2 * p);
      flip = (r >= p);
      leg = flip ? r - p : r;
    end else begin
      leg = longint'(tm) % p;
      flip = (sh_dir == DIR_REV);
    end
    lead = (leg * (a + t)) / p - t;
    return train_sample(flip ? a - longint'(crd) : longint'(crd), lead, w, cnt);
  endfunction

  // color side: check every transfer, stall ready at random
  always @(posedge clk) begin
    logic [23:0] exp_c;
    if (rst) begin
      col.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (col.valid && col.ready) begin
        if (color_q.size() == 0) begin
          $display("%0t unexpected color: expected none, actual %h%h%h",
                   $time, col.red, col.green, col.blue);
          err_count++;
        end else begin
          exp_c = color_q.pop_front();
          if (col.red !== exp_c[23:16]) begin
            $display("%0t red: expected %h actual %h", $time, exp_c[23:16], col.red);
            err_count++;
          end
          if (col.green !== exp_c[15:8]) begin
            $display("%0t green: expected %h actual %h", $time, exp_c[15:8], col.green);
            err_count++;
          end
          if (col.blue !== exp_c[7:0]) begin
            $display("%0t blue: expected %h actual %h", $time, exp_c[7:0], col.blue);
            err_count++;
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 17);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      col.ready <= (stall_left == 0);
    end
  end

  task automatic wait_idle();
    while (color_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // the bus goes idle after the access phase, keeping back-to-back writes apart
  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 6'(idx) << 3;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SPEED:  sh_speed  = val[7:0];
      REG_BAND:   sh_band   = val[16:0];
      REG_AXIS:   sh_axis   = val[18:0];
      REG_DIR:    sh_dir    = val[2:0];
      REG_COUNT:  sh_count  = val[2:0];
      REG_PAL_LO: sh_pal_lo = val[47:0];
      REG_PAL_HI: sh_pal_hi = val[47:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [7:0] spd, logic [16:0] bw, logic [18:0] ax, logic [2:0] dr,
                         logic [2:0] cnt, logic [47:0] lo, logic [47:0] hi);
    write_reg(REG_SPEED, 64'(spd));
    write_reg(REG_BAND, 64'(bw));
    write_reg(REG_AXIS, 64'(ax));
    write_reg(REG_DIR, 64'(dr));
    write_reg(REG_COUNT, 64'(cnt));
    write_reg(REG_PAL_LO, 64'(lo));
    write_reg(REG_PAL_HI, 64'(hi));
  endtask

  // one pixel transfer; valid stays up between back-to-back pixels
  task automatic send_pixel(logic [31:0] tm, logic [18:0] crd);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid   <= 1'b1;
    pix.time_ms <= tm;
    pix.coord   <= crd;
    do @(posedge clk); while (!pix.ready);
    color_q.push_back(pixel_color(tm, crd));
  endtask

  task automatic end_burst();
    pix.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [18:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 19'($urandom);
    if (sel == 1) return 19'(262144);
    return 19'($urandom_range(0, sh_axis));
  endfunction

  task automatic test_defaults();
    send_pixel(32'd0, 19'd0);
    send_pixel(32'hFFFF_FFFF, 19'd262144);
    send_pixel(32'd1000, 19'h7FFFF);
    send_pixel(32'd1234, 19'd32768);
    end_burst();
    wait_idle();
  endtask

  task automatic test_directions();
    for (int d = 0; d < 8; d++) begin
      set_all(8'd100, 17'd8192, 19'd65536, 3'(d), 3'd4, 48'hFF0000_00FF00,
              48'h0000FF_FFFFFF);
      send_pixel(32'd0, 19'd30000);
      send_pixel(32'd150, 19'd40000);
      send_pixel(32'd299, 19'd65536);
      end_burst();
      wait_idle();
    end
  endtask

  task automatic test_special_config();
    // zero band width, zero count, count above max, speed extremes, wide axis
    set_all(8'd0, 17'd0, 19'd262144, DIR_DUAL_OUT, 3'd0, 48'hFFFFFF_FFFFFF, 48'hFFFFFF_FFFFFF);
    send_pixel(32'd777, 19'd131072);
    send_pixel(32'd3999, 19'd1);
    end_burst();
    wait_idle();
    set_all(8'd255, 17'd65536, 19'h7FFFF, DIR_PINGPONG, 3'd7, 48'h123456_ABCDEF,
            48'h808080_FEDCBA);
    send_pixel(32'd450, 19'd100000);
    send_pixel(32'hFFFF_FFFF, 19'h7FFFF);
    end_burst();
    wait_idle();
    set_all(8'd1, 17'd1, 19'd65536, DIR_REV, 3'd5, 48'hFFFFFF_000001, 48'h7F7F7F_010203);
    send_pixel(32'd2000, 19'd65536);
    send_pixel(32'd0, 19'd0);
    end_burst();
    wait_idle();
  endtask

  task automatic test_random();
    logic [16:0] bw;
    logic [18:0] ax;
    for (int ph = 0; ph < 20; ph++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: bw = 17'($urandom);
        1: bw = 17'($urandom_range(0, 4096));
        2: bw = 17'(65536);
        default: bw = 17'($urandom_range(1, 32768));
      endcase
      case ($urandom_range(0, 3))
        0: ax = 19'(65536);
        1: ax = 19'(262144);
        2: ax = 19'($urandom);
        default: ax = 19'($urandom_range(65536, 262144));
      endcase
      set_all(8'($urandom), bw, ax, 3'($urandom), 3'($urandom),
              {16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)});
      for (int i = 0; i < 100; i++) send_pixel($urandom, rand_coord());
      end_burst();
      wait_idle();
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix.valid = 1'b0;
    pix.time_ms = '0;
    pix.coord = '0;
    col.ready = 1'b0;
    err_count = 0;
    cycles = 0;
    no_idle = 1'b0;
    sh_speed = 8'd50;
    sh_band = 17'd4096;
    sh_axis = 19'd65536;
    sh_dir = DIR_FWD;
    sh_count = 3'd1;
    sh_pal_lo = '0;
    sh_pal_hi = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_directions();
    test_special_config();
    test_random();
    wait_idle();
    if (err_count == 0) begin
      $display("color_train_sweep_sampler_top_tb: clean");
    end else begin
      $display("color_train_sweep_sampler_top_tb: errors");
    end
    $finish;
  end

endmodule
